@@ hdl/bdlp_pkg.sv @@
// Shared types and constants for the button debounce / long-press unit.
package bdlp_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int FIELD_W     = 16;
  localparam int SPAN_W      = 16;
  localparam int TIME_W      = 20;
  localparam int CFG_IDX_W   = 1;

  localparam logic [TIME_W-1:0] HELD_MAX        = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] BOUNCE_RESET    = TIME_W'(20);
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = TIME_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNCE_TIME     = 1'b0,
    REG_LONG_PRESS_TIME = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_PRESSED = 2'd1,
    PH_LONG    = 2'd2
  } phase_t;

endpackage

@@ hdl/bdlp_if.sv @@
// Valid/ready channel interfaces for ticks and per-tick results.
interface bdlp_tick_if
  import bdlp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SPAN_W-1:0] elapsed_span;
  logic [FIELD_W-1:0] raw_pressed;

  modport source (output valid, elapsed_span, raw_pressed, input ready);
  modport sink   (input valid, elapsed_span, raw_pressed, output ready);
endinterface

interface bdlp_result_if
  import bdlp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] down_events;
  logic [FIELD_W-1:0] click_events;
  logic [FIELD_W-1:0] long_events;
  logic [FIELD_W-1:0] long_release_events;
  logic [FIELD_W-1:0] pressed_mask;

  modport source (output valid, down_events, click_events, long_events,
                  long_release_events, pressed_mask, input ready);
  modport sink   (input valid, down_events, click_events, long_events,
                  long_release_events, pressed_mask, output ready);
endinterface

@@ hdl/button_debounce_long_press_unit.sv @@
// A tick passes the tick register, then the result register; a low
// result.ready holds it. Throughput: one tick per cycle when not held; all
// buttons are updated in parallel lanes in one pass, which also carries
// each button's phase and held time forward to the next tick.
// Synchronous reset: buttons go up with zero held time, thresholds return to
// 20 and 1000, both pipeline stages empty.
module button_debounce_long_press_unit
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  bdlp_tick_if.sink            tick,
  bdlp_result_if.source        result
);

  // configuration
  logic [TIME_W-1:0] bounce_time;
  logic [TIME_W-1:0] long_press_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_time     <= BOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOUNCE_TIME:     bounce_time     <= cfg_data;
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick register
  logic               tick_valid;
  logic [SPAN_W-1:0]  span;
  logic [FIELD_W-1:0] raw;
  logic               advance;
  logic               tick_fire;

  assign advance   = !result.valid || result.ready;
  assign tick_fire = tick_valid && advance;
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      span <= tick.elapsed_span;
      raw  <= tick.raw_pressed;
    end
  end

  // per-button state
  phase_t            phase          [NUM_BUTTONS];
  phase_t            phase_next     [NUM_BUTTONS];
  logic [TIME_W-1:0] held_time      [NUM_BUTTONS];
  logic [TIME_W-1:0] held_time_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] held;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held[i] = (i < FIELD_W) ? raw[i] : 1'b0;
    end
  end

  // next state per lane
  always_comb begin
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] acc;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      sum = {1'b0, held_time[i]} + (TIME_W+1)'(span);
      acc = sum[TIME_W] ? HELD_MAX : sum[TIME_W-1:0];
      phase_next[i]     = phase[i];
      held_time_next[i] = held_time[i];
      unique case (phase[i])
        PH_UP: begin
          held_time_next[i] = held[i] ? acc : '0;
          if ((held[i] ? acc : '0) >= bounce_time) phase_next[i] = PH_PRESSED;
        end
        PH_PRESSED: begin
          held_time_next[i] = held[i] ? acc : '0;
          if (!held[i]) phase_next[i] = PH_UP;
          if ((held[i] ? acc : '0) >= long_press_time) phase_next[i] = PH_LONG;
        end
        PH_LONG: begin
          held_time_next[i] = held[i] ? acc : '0;
          if (!held[i]) phase_next[i] = PH_UP;
        end
        default: ;  // unused code holds
      endcase
    end
  end

  // events per lane
  logic [NUM_BUTTONS-1:0] down_vec, click_vec, long_vec, lrel_vec, pmask_vec;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      down_vec[i]  = (phase[i] == PH_UP) && (phase_next[i] == PH_PRESSED);
      click_vec[i] = (phase[i] == PH_PRESSED) && !held[i];
      long_vec[i]  = (phase[i] == PH_PRESSED) && (phase_next[i] == PH_LONG);
      lrel_vec[i]  = (phase[i] == PH_LONG) && !held[i];
      pmask_vec[i] = (phase_next[i] != PH_UP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase[i]     <= PH_UP;
        held_time[i] <= '0;
      end
    end else if (tick_fire) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase[i]     <= phase_next[i];
        held_time[i] <= held_time_next[i];
      end
    end
  end

  // result register; buttons past the field width do not show
  logic [FIELD_W-1:0] down_f, click_f, long_f, lrel_f, pmask_f;

  always_comb begin
    for (int j = 0; j < FIELD_W; j++) begin
      down_f[j]  = (j < NUM_BUTTONS) ? down_vec[j]  : 1'b0;
      click_f[j] = (j < NUM_BUTTONS) ? click_vec[j] : 1'b0;
      long_f[j]  = (j < NUM_BUTTONS) ? long_vec[j]  : 1'b0;
      lrel_f[j]  = (j < NUM_BUTTONS) ? lrel_vec[j]  : 1'b0;
      pmask_f[j] = (j < NUM_BUTTONS) ? pmask_vec[j] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      result.down_events         <= down_f;
      result.click_events        <= click_f;
      result.long_events         <= long_f;
      result.long_release_events <= lrel_f;
      result.pressed_mask        <= pmask_f;
    end
  end

endmodule

@@ hdl/bdlp_checker.sv @@
// Port-level checks for the button debounce / long-press unit.
module bdlp_checker
  import bdlp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [FIELD_W-1:0] down_events,
  input logic [FIELD_W-1:0] click_events,
  input logic [FIELD_W-1:0] long_events,
  input logic [FIELD_W-1:0] long_release_events,
  input logic [FIELD_W-1:0] pressed_mask
);

  // a down event leaves the button pressed
  a_down_pressed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((down_events & ~pressed_mask) == '0))
    else $error("down event on a button reported up");

  // a long event leaves the button pressed
  a_long_pressed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((long_events & ~pressed_mask) == '0))
    else $error("long event on a button reported up");

  // click and long-release come from different phases
  a_release_kinds: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((click_events & long_release_events) == '0))
    else $error("click and long release on the same button");

  // a long release leaves the button up
  a_lrel_up: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((long_release_events & pressed_mask) == '0))
    else $error("long release on a button still pressed");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(pressed_mask)
                                   && $stable(down_events)))
    else $error("result changed while stalled");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .res_valid           (result.valid),
  .res_ready           (result.ready),
  .down_events         (result.down_events),
  .click_events        (result.click_events),
  .long_events         (result.long_events),
  .long_release_events (result.long_release_events),
  .pressed_mask        (result.pressed_mask)
);
